FILE: hdl/ssis_pkg.sv
// Shared types, constants and helpers for the crank synced spark and injection scheduler.
package ssis_pkg;

    localparam int CNT_W      = 16;
    localparam int LEN_W      = 14;
    localparam int ADV_W      = 9;
    localparam int DIVD_W     = 25;
    localparam int DIVS_W     = 16;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Reciprocal of a full turn: (x * RECIP_360) >> RECIP_SH is x / 360 for x < 2^25
    localparam int RECIP_W  = 26;
    localparam int RECIP_SH = 34;
    localparam int RPROD_W  = RECIP_SH + CNT_W;
    localparam logic [RECIP_W-1:0] RECIP_360 = RECIP_W'(47721859);

    // Ticks per minute at 4 us per tick.
    localparam logic [DIVD_W-1:0] TICKS_PER_MIN = DIVD_W'(15000000);
    localparam logic [ADV_W-1:0]  DEG_FULL      = ADV_W'(360);
    localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

    localparam logic [15:0]      SPARK_LEN_RST = 16'd1000;
    localparam logic [ADV_W-1:0] INJ_ADV_RST   = ADV_W'(140);

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_EDGE      = 2'd1,
        OP_SPARK_ADV = 2'd2,
        OP_INJ_LEN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_SPARK_LEN = 2'd0,
        CFG_INJ_ADV   = 2'd1,
        CFG_SPARK_INV = 2'd2,
        CFG_INJ_INV   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPD_START,
        ST_SPD_WAIT,
        ST_MUL,
        ST_ANG,
        ST_PUSH
    } state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;
        logic mul;
        logic div_start;
        logic finish_speed;
        logic finish_angle;
        logic push;
    } cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic div_done;
    } stat_t;

    // Degrees left of the revolution; advances above a full turn count as a full turn.
    function automatic logic [ADV_W-1:0] adv_remain(input logic [15:0] adv);
        logic [ADV_W-1:0] adv_c;
        adv_c = (adv > {7'd0, DEG_FULL}) ? DEG_FULL : adv[ADV_W-1:0];
        return DEG_FULL - adv_c;
    endfunction

endpackage

FILE: hdl/crank_synced_spark_injection_scheduler.sv
// Top level of the crank synced spark and injection scheduler.
//
//  channel   handshake            payload
//  s_        s_valid / s_ready    s_op, s_value, s_engine_active
//  m_        m_valid / m_ready    m_spark_pin, m_inj_pin, m_rpm,
//                                 m_predicted_ticks, m_counter_wrapped
//  cfg_      cfg_wr_en            cfg_index, cfg_wdata
//
// One word in, one word out. A tick word goes from idle straight to the push stage;
// an edge word starts the 25-step rpm divider and waits for it; an advance or length
// word passes a multiply state, then a reciprocal multiply state for the angle offset.
// Sync reset (aresetn low) loads default config, clears engine and control state.
// A word is taken in idle even while the previous result waits on m_ready; its own
// result then waits in the push stage until the output register is free.
module crank_synced_spark_injection_scheduler
    import ssis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_value,
    input  logic        s_engine_active,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_spark_pin,
    output logic        m_inj_pin,
    output logic [15:0] m_rpm,
    output logic [15:0] m_predicted_ticks,
    output logic        m_counter_wrapped,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t stat;

    ssis_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    ssis_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_engine_active   (s_engine_active),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .m_spark_pin       (m_spark_pin),
        .m_inj_pin         (m_inj_pin),
        .m_rpm             (m_rpm),
        .m_predicted_ticks (m_predicted_ticks),
        .m_counter_wrapped (m_counter_wrapped)
    );

endmodule

FILE: hdl/ssis_div.sv
// Restoring divider, one quotient bit per cycle, used for the rpm divide.
module ssis_div
    import ssis_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [DIVD_W-1:0] quotient
);

    logic [DIVD_W-1:0]    quo_reg;
    logic [DIVS_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIVS_W:0] shifted;
    logic [DIVS_W:0] trial;
    logic            fits;

    // One trial subtract per step
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVD_W-1]};
        trial   = shifted - {1'b0, divisor};
        fits    = (shifted >= {1'b0, divisor});
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Quotient and remainder shift
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIVD_W-2:0], fits};
            rem_reg <= fits ? trial[DIVS_W-1:0] : shifted[DIVS_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // A run is never restarted while it is still shifting
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider restarted while busy");

    // Done only closes a run that was in progress
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a run");

endmodule

FILE: hdl/ssis_dp.sv
// Datapath: tick counter, period prediction, channel schedules, config and output word.
module ssis_dp
    import ssis_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic [1:0]  s_op,
    input  logic [15:0] s_value,
    input  logic        s_engine_active,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    output logic        m_spark_pin,
    output logic        m_inj_pin,
    output logic [15:0] m_rpm,
    output logic [15:0] m_predicted_ticks,
    output logic        m_counter_wrapped
);

    // Configuration
    logic [15:0]      spark_len_reg;
    logic [ADV_W-1:0] inj_adv_reg;
    logic             spark_inv_reg;
    logic             inj_inv_reg;

    // Engine state
    logic [CNT_W-1:0] tick_cnt_reg;
    logic [CNT_W-1:0] last_edge_reg;
    logic [CNT_W-1:0] last_period_reg;
    logic [CNT_W-1:0] pred_reg;
    logic [CNT_W-1:0] speed_reg;
    logic             wrap_reg;

    // Channel 0 ignition, channel 1 injection
    logic [CNT_W-1:0] pend_start_reg [2];
    logic [LEN_W-1:0] pend_len_reg   [2];
    logic [CNT_W-1:0] act_start_reg  [2];
    logic [LEN_W-1:0] act_len_reg    [2];
    logic [CNT_W-1:0] cmp_reg        [2];
    logic [1:0]       pulse_on_reg;
    logic [1:0]       armed_reg;

    // Angle offset work
    logic [ADV_W-1:0]  remain_reg;
    logic              ang_ch_reg;
    logic [DIVD_W-1:0] prod_reg;

    // Output word
    logic              spark_pin_reg;
    logic              inj_pin_reg;
    logic [15:0]       rpm_reg;
    logic [15:0]       pred_out_reg;
    logic              wrap_out_reg;

    op_t               op;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  period;
    logic [CNT_W+1:0]  pred_wide;
    logic [CNT_W-1:0]  pred_sat;
    logic [15:0]       adv_src;
    logic [RPROD_W-1:0] recip_prod;
    logic              div_done;
    logic [DIVD_W-1:0] div_quo;

    assign op      = op_t'(s_op);
    assign cnt_inc = tick_cnt_reg + 1'b1;
    assign adv_src = (op == OP_SPARK_ADV) ? s_value : {7'd0, inj_adv_reg};

    // Next period prediction, 2*period - previous, held to 1..65535
    always_comb begin
        period    = tick_cnt_reg - last_edge_reg;
        pred_wide = {1'b0, period, 1'b0} - {2'b00, last_period_reg};
        if (pred_wide[CNT_W+1] || (pred_wide == '0)) begin
            pred_sat = CNT_W'(1);
        end else if (pred_wide[CNT_W]) begin
            pred_sat = CNT_MAX;
        end else begin
            pred_sat = pred_wide[CNT_W-1:0];
        end
    end

    // Offset over a full turn by reciprocal multiply; the quotient fits 16 bits
    assign recip_prod = RPROD_W'(prod_reg) * RPROD_W'(RECIP_360);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spark_len_reg <= SPARK_LEN_RST;
            inj_adv_reg   <= INJ_ADV_RST;
            spark_inv_reg <= 1'b0;
            inj_inv_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SPARK_LEN: spark_len_reg <= cfg_wdata;
                CFG_INJ_ADV:   inj_adv_reg   <= cfg_wdata[ADV_W-1:0];
                CFG_SPARK_INV: spark_inv_reg <= cfg_wdata[0];
                CFG_INJ_INV:   inj_inv_reg   <= cfg_wdata[0];
                default:       spark_len_reg <= spark_len_reg;
            endcase
        end
    end

    // Engine state and channel schedules
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_cnt_reg    <= '0;
            last_edge_reg   <= '0;
            last_period_reg <= '0;
            pred_reg        <= '0;
            speed_reg       <= '0;
            wrap_reg        <= 1'b0;
            pulse_on_reg    <= '0;
            armed_reg       <= '0;
            for (int ch = 0; ch < 2; ch++) begin
                pend_start_reg[ch] <= '0;
                pend_len_reg[ch]   <= '0;
                act_start_reg[ch]  <= '0;
                act_len_reg[ch]    <= '0;
                cmp_reg[ch]        <= '0;
            end
        end else begin
            if (cmd.accept) begin
                wrap_reg <= (op == OP_TICK) && (tick_cnt_reg == CNT_MAX);
                case (op)
                    OP_TICK: begin
                        tick_cnt_reg <= cnt_inc;
                        for (int ch = 0; ch < 2; ch++) begin
                            if (armed_reg[ch] && (cmp_reg[ch] == cnt_inc)) begin
                                pulse_on_reg[ch] <= !pulse_on_reg[ch];
                                cmp_reg[ch] <= pulse_on_reg[ch] ? act_start_reg[ch]
                                             : cmp_reg[ch] + {2'b00, act_len_reg[ch]};
                            end
                        end
                    end
                    OP_EDGE: begin
                        last_edge_reg   <= tick_cnt_reg;
                        last_period_reg <= period;
                        pred_reg        <= pred_sat;
                        if (s_engine_active) begin
                            for (int ch = 0; ch < 2; ch++) begin
                                act_start_reg[ch] <= tick_cnt_reg + pend_start_reg[ch];
                                act_len_reg[ch]   <= pend_len_reg[ch];
                                armed_reg[ch]     <= 1'b1;
                                if (!pulse_on_reg[ch]) begin
                                    cmp_reg[ch] <= tick_cnt_reg + pend_start_reg[ch];
                                end
                            end
                        end
                    end
                    OP_SPARK_ADV: pend_len_reg[0] <= spark_len_reg[15:2];
                    OP_INJ_LEN:   pend_len_reg[1] <= s_value[15:2];
                    default:      tick_cnt_reg <= tick_cnt_reg;
                endcase
            end
            if (cmd.finish_speed) begin
                speed_reg <= (|div_quo[DIVD_W-1:CNT_W]) ? CNT_MAX : div_quo[CNT_W-1:0];
            end
            if (cmd.finish_angle) begin
                pend_start_reg[ang_ch_reg] <= recip_prod[RPROD_W-1:RECIP_SH];
            end
        end
    end

    // Angle offset operands: remaining degrees, then period times degrees
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            remain_reg <= adv_remain(adv_src);
            ang_ch_reg <= (op == OP_INJ_LEN);
        end
        if (cmd.mul) begin
            prod_reg <= {9'd0, pred_reg} * {16'd0, remain_reg};
        end
    end

    // rpm divider: ticks per minute over the prediction
    ssis_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (TICKS_PER_MIN),
        .divisor  (pred_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign stat.div_done = div_done;

    // Output word
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            spark_pin_reg <= pulse_on_reg[0] ^ spark_inv_reg;
            inj_pin_reg   <= pulse_on_reg[1] ^ inj_inv_reg;
            rpm_reg       <= speed_reg;
            pred_out_reg  <= pred_reg;
            wrap_out_reg  <= wrap_reg;
        end
    end

    assign m_spark_pin       = spark_pin_reg;
    assign m_inj_pin         = inj_pin_reg;
    assign m_rpm             = rpm_reg;
    assign m_predicted_ticks = pred_out_reg;
    assign m_counter_wrapped = wrap_out_reg;

    // The prediction is never zero after an edge, so the rpm divide never sees zero
    a_pred_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (op == OP_EDGE)) |=> (pred_reg != '0))
        else $error("zero period prediction after edge");

endmodule

FILE: hdl/ssis_ctrl.sv
// Controller: sequences accept, multiply, divide and output push for each word.
module ssis_ctrl
    import ssis_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_op,
    output logic       m_valid,
    input  logic       m_ready,
    output cmd_t       cmd,
    input  stat_t      stat
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (op_t'(s_op))
                        OP_TICK: state_next = ST_PUSH;
                        OP_EDGE: state_next = ST_SPD_START;
                        default: state_next = ST_MUL;
                    endcase
                end
            end
            ST_SPD_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SPD_WAIT;
            end
            ST_SPD_WAIT: begin
                if (stat.div_done) begin
                    cmd.finish_speed = 1'b1;
                    state_next       = ST_PUSH;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ANG;
            end
            ST_ANG: begin
                cmd.finish_angle = 1'b1;
                state_next       = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on push, cleared when taken
    always_comb begin
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    // A waiting word is never dropped
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> m_valid_reg)
        else $error("output word lost while stalled");

    // A tick goes straight to the output stage
    a_tick_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && (op_t'(s_op) == OP_TICK)) |=> (state_reg == ST_PUSH))
        else $error("tick did not go to push");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the crank synced spark and injection scheduler.
module tb
    import ssis_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TICKS_PER_MINUTE = 15_000_000;
    localparam int unsigned FULL_TURN_DEG    = 360;
    localparam int unsigned CYCLE_LIMIT      = 200_000;
    localparam int          IDLE_PCT         = 31;
    localparam int          SETTLE_CYCLES    = 40;
    localparam int          MAX_REPORTS      = 100;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_op;
    logic [15:0] s_value;
    logic        s_engine_active;
    logic        m_valid;
    logic        m_ready;
    logic        m_spark_pin;
    logic        m_inj_pin;
    logic [15:0] m_rpm;
    logic [15:0] m_predicted_ticks;
    logic        m_counter_wrapped;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    // One expected result word
    typedef struct packed {
        logic        spark_pin;
        logic        inj_pin;
        logic [15:0] rpm;
        logic [15:0] predicted_ticks;
        logic        counter_wrapped;
    } sched_word_t;

    sched_word_t sched_out_q[$];

    // Scheduler model state and register copies
    logic [15:0] cfg_spark_len;
    logic [8:0]  cfg_inj_adv;
    logic        cfg_spark_inv;
    logic        cfg_inj_inv;
    logic [15:0] tick_cnt;
    logic [15:0] edge_stamp;
    logic [15:0] prev_period;
    logic [15:0] pred_period;
    logic [15:0] speed;
    logic [15:0] next_start[2];
    logic [15:0] cur_start[2];
    logic [15:0] match_pt[2];
    logic [13:0] next_len[2];
    logic [13:0] cur_len[2];
    logic        pulse_on[2];
    logic        armed[2];

    logic        idle_on = 1'b1;
    int          words_sent;
    int          results_checked;
    int          wraps_seen;
    int          pulses_started;
    int          errors;
    int unsigned cycle_count;

    crank_synced_spark_injection_scheduler DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_value           (s_value),
        .s_engine_active   (s_engine_active),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_spark_pin       (m_spark_pin),
        .m_inj_pin         (m_inj_pin),
        .m_rpm             (m_rpm),
        .m_predicted_ticks (m_predicted_ticks),
        .m_counter_wrapped (m_counter_wrapped),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t ns: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Ticks from TDC to the start of a pulse for a given advance
    function automatic logic [15:0] advance_offset(input logic [15:0] adv_deg);
        int unsigned deg;
        deg = (adv_deg > FULL_TURN_DEG) ? FULL_TURN_DEG : adv_deg;
        return 16'((32'(pred_period) * (FULL_TURN_DEG - deg)) / FULL_TURN_DEG);
    endfunction

    task automatic reset_engine_model();
        cfg_spark_len = 16'd1000;
        cfg_inj_adv   = 9'd140;
        cfg_spark_inv = 1'b0;
        cfg_inj_inv   = 1'b0;
        tick_cnt      = '0;
        edge_stamp    = '0;
        prev_period   = '0;
        pred_period   = '0;
        speed         = '0;
        for (int ch = 0; ch < 2; ch++) begin
            next_start[ch] = '0;
            cur_start[ch]  = '0;
            match_pt[ch]   = '0;
            next_len[ch]   = '0;
            cur_len[ch]    = '0;
            pulse_on[ch]   = 1'b0;
            armed[ch]      = 1'b0;
        end
    endtask

    // Advance the model by one accepted word and queue the result it gives
    task automatic predict_engine_word(input op_t op, input logic [15:0] value,
                                       input logic active);
        sched_word_t w;
        logic [15:0] latched;
        logic [15:0] period;
        int          pred_i;
        int unsigned rate;
        w.counter_wrapped = 1'b0;
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt == 16'd0) begin
                    w.counter_wrapped = 1'b1;
                    wraps_seen++;
                end
                // compare toggling: on adds the length, off reloads the start
                for (int ch = 0; ch < 2; ch++) begin
                    if (armed[ch] && match_pt[ch] == tick_cnt) begin
                        if (!pulse_on[ch]) begin
                            pulse_on[ch] = 1'b1;
                            match_pt[ch] = match_pt[ch] + 16'(cur_len[ch]);
                            pulses_started++;
                        end else begin
                            pulse_on[ch] = 1'b0;
                            match_pt[ch] = cur_start[ch];
                        end
                    end
                end
            end
            OP_EDGE: begin
                latched    = tick_cnt;
                period     = latched - edge_stamp;
                edge_stamp = latched;
                pred_i     = 2 * int'(period) - int'(prev_period);
                if (pred_i < 1) pred_i = 1;
                else if (pred_i > 65535) pred_i = 65535;
                pred_period = 16'(pred_i);
                prev_period = period;
                rate  = TICKS_PER_MINUTE / 32'(pred_period);
                speed = (rate > 65535) ? 16'hFFFF : 16'(rate);
                // a running pulse keeps its compare point until it ends
                if (active) begin
                    for (int ch = 0; ch < 2; ch++) begin
                        cur_start[ch] = latched + next_start[ch];
                        cur_len[ch]   = next_len[ch];
                        if (!pulse_on[ch]) match_pt[ch] = cur_start[ch];
                        armed[ch] = 1'b1;
                    end
                end
            end
            OP_SPARK_ADV: begin
                next_start[0] = advance_offset(value);
                next_len[0]   = 14'(cfg_spark_len >> 2);
            end
            OP_INJ_LEN: begin
                next_start[1] = advance_offset({7'd0, cfg_inj_adv});
                next_len[1]   = 14'(value >> 2);
            end
            default: ;
        endcase
        w.spark_pin       = pulse_on[0] ^ cfg_spark_inv;
        w.inj_pin         = pulse_on[1] ^ cfg_inj_inv;
        w.rpm             = speed;
        w.predicted_ticks = pred_period;
        sched_out_q.push_back(w);
    endtask

    // Drive one word; valid stays up until the handshake
    task automatic send_word(input op_t op, input logic [15:0] value, input logic active);
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_op            <= op;
        s_value         <= value;
        s_engine_active <= active;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_engine_word(op, value, active);
        words_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_word(OP_TICK, 16'($urandom), 1'($urandom));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sched_out_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            CFG_SPARK_LEN: cfg_spark_len = data;
            CFG_INJ_ADV:   cfg_inj_adv   = data[8:0];
            CFG_SPARK_INV: cfg_spark_inv = data[0];
            CFG_INJ_INV:   cfg_inj_inv   = data[0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [15:0] spark_len, input logic [8:0] inj_adv,
                                input logic spark_inv, input logic inj_inv);
        write_reg(CFG_SPARK_LEN, spark_len);
        write_reg(CFG_INJ_ADV, {7'd0, inj_adv});
        write_reg(CFG_SPARK_INV, {15'd0, spark_inv});
        write_reg(CFG_INJ_INV, {15'd0, inj_inv});
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Directed: every op, field extremes, clamping and pulse corner cases
    task automatic test_directed_ops();
        send_word(OP_TICK, 16'hFFFF, 1'b1);         // engine_active ignored on ticks
        send_word(OP_SPARK_ADV, 16'd0, 1'b0);       // no prediction yet: zero offset
        send_word(OP_INJ_LEN, 16'hFFFF, 1'b1);      // longest injection length
        send_word(OP_EDGE, 16'd0, 1'b0);            // engine stopped: prediction and speed only
        send_word(OP_EDGE, 16'hFFFF, 1'b0);         // back to back: prediction clamps low
        send_ticks(4);
        send_word(OP_EDGE, 16'd0, 1'b0);            // prediction of 8 ticks
        send_word(OP_SPARK_ADV, 16'd360, 1'b1);     // full turn, zero offset
        send_word(OP_SPARK_ADV, 16'd361, 1'b0);     // beyond a full turn
        send_word(OP_SPARK_ADV, 16'hFFFF, 1'b1);
        send_word(OP_SPARK_ADV, 16'd180, 1'b0);
        send_word(OP_INJ_LEN, 16'd0, 1'b1);
        send_word(OP_INJ_LEN, 16'd8, 1'b0);
        send_word(OP_EDGE, 16'd0, 1'b1);            // arm both channels
        send_ticks(6);                              // both on, injector off again
        send_word(OP_EDGE, 16'd0, 1'b1);            // edge while spark pulse is on
        send_ticks(2);
    endtask

    // Mostly well-formed revolutions with random content, some noise
    task automatic test_random_cycles(input int n_words);
        int          stop_at;
        int          n;
        logic [15:0] adv;
        logic [15:0] inj;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            if ($urandom_range(99) < 85) begin
                case ($urandom_range(2))
                    0: adv = 16'($urandom_range(359));
                    1: adv = 16'($urandom_range(400, 360));
                    default: adv = 16'($urandom);
                endcase
                inj = ($urandom_range(99) < 60) ? 16'($urandom_range(200)) : 16'($urandom);
                send_word(OP_SPARK_ADV, adv, 1'($urandom));
                send_word(OP_INJ_LEN, inj, 1'($urandom));
                send_word(OP_EDGE, 16'($urandom), $urandom_range(99) < 90);
                send_ticks(($urandom_range(99) < 10) ? $urandom_range(1)
                                                     : $urandom_range(60, 2));
            end else begin
                n = $urandom_range(4, 1);
                repeat (n) send_word(op_t'($urandom_range(3)), 16'($urandom), 1'($urandom));
            end
        end
    endtask

    // Revolutions without idling: back to back words, zero-length spark pulses
    // and pulses running across edges
    task automatic test_long_revolutions();
        int n;
        int ticks_done;
        idle_on = 1'b0;
        send_word(OP_SPARK_ADV, 16'd359, 1'b1);
        send_word(OP_INJ_LEN, 16'd2, 1'b1);
        send_word(OP_EDGE, 16'd0, 1'b1);
        send_ticks(40);
        send_word(OP_EDGE, 16'd0, 1'b1);
        ticks_done = 40;
        while (ticks_done < 140) begin
            send_word(OP_SPARK_ADV, 16'($urandom_range(359)), 1'b0);
            send_word(OP_INJ_LEN, 16'($urandom_range(400)), 1'b0);
            send_word(OP_EDGE, 16'($urandom), $urandom_range(9) != 0);
            n = $urandom_range(30, 8);
            send_ticks(n);
            ticks_done += n;
        end
        idle_on = 1'b1;
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
        end
    endfunction

    // Compare each result word with the oldest expectation
    always @(posedge aclk) begin : check_results
        sched_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (sched_out_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: result word with nothing expected, actual rpm %0d",
                             $time, m_rpm);
            end else begin
                want = sched_out_q.pop_front();
                check_field("spark_pin", want.spark_pin, m_spark_pin);
                check_field("inj_pin", want.inj_pin, m_inj_pin);
                check_field("rpm", want.rpm, m_rpm);
                check_field("predicted_ticks", want.predicted_ticks, m_predicted_ticks);
                check_field("counter_wrapped", want.counter_wrapped, m_counter_wrapped);
                results_checked++;
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_op            = OP_TICK;
        s_value         = '0;
        s_engine_active = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_SPARK_LEN;
        cfg_wdata       = '0;
        reset_engine_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_ops();
        wait_drained();
        program_regs(16'd40, 9'd0, 1'b1, 1'b0);
        test_random_cycles(150);
        wait_drained();
        program_regs(16'hFFFF, 9'd359, 1'b0, 1'b1);
        test_random_cycles(150);
        wait_drained();
        program_regs(16'd3, 9'd300, 1'b0, 1'b1);
        test_long_revolutions();
        wait_drained();
        program_regs(16'($urandom_range(400)), 9'($urandom), 1'b1, 1'b1);
        test_random_cycles(150);
        wait_drained();
        program_regs(16'd0, 9'h1FF, 1'b0, 1'b0);
        test_random_cycles(150);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d words over directed, random and long revolution phases", words_sent);
        $display("with %0d results checked, %0d counter wraps and %0d pulses started",
                 results_checked, wraps_seen, pulses_started);
        if (errors == 0 && sched_out_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/ssis_pkg.sv
hdl/ssis_div.sv
hdl/ssis_dp.sv
hdl/ssis_ctrl.sv
hdl/crank_synced_spark_injection_scheduler.sv
tb/tb.sv
